FILE: rtl/tbbtb_pkg.sv
// ----------------------------------------------------------------------------
// tbbtb_pkg
// Shared types, codes and prediction-state functions of the two-bank
// branch target buffer.
// ----------------------------------------------------------------------------
package tbbtb_pkg;

  localparam int unsigned PC_W    = 32;
  localparam int unsigned PC_STEP = 4;

  typedef logic [1:0] ctr_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] verdict_t;
  typedef logic [1:0] wr_action_t;

  localparam mode_t MODE_SAT     = 2'd0;
  localparam mode_t MODE_BIMODAL = 2'd1;
  localparam mode_t MODE_ALT     = 2'd2;

  localparam verdict_t VERDICT_NONE    = 2'd0;
  localparam verdict_t VERDICT_CORRECT = 2'd1;
  localparam verdict_t VERDICT_WRONG   = 2'd2;

  localparam wr_action_t WR_NONE  = 2'd0;
  localparam wr_action_t WR_BANK0 = 2'd1;
  localparam wr_action_t WR_BANK1 = 2'd2;

  localparam ctr_t CTR_0 = 2'd0;
  localparam ctr_t CTR_1 = 2'd1;
  localparam ctr_t CTR_2 = 2'd2;
  localparam ctr_t CTR_3 = 2'd3;

  typedef struct packed {
    logic            skipped;
    logic            branch_taken;
    logic            hit;
    logic            hit_bank;
    logic            predicted_taken;
    logic [PC_W-1:0] predicted_target;
    verdict_t        verdict;
    logic            collision;
    wr_action_t      write_action;
  } res_t;

  function automatic ctr_t fresh_ctr(input mode_t mode);
    return (mode == MODE_BIMODAL) ? CTR_1 : CTR_0;
  endfunction

  function automatic ctr_t next_ctr(input ctr_t ctr, input logic taken, input mode_t mode);
    ctr_t a;
    ctr_t b;
    ctr_t r;
    a = (mode == MODE_ALT) ? CTR_1 : CTR_0;
    b = (mode == MODE_BIMODAL || mode == MODE_ALT) ? CTR_0 : CTR_1;
    case (ctr)
      CTR_0:   r = taken ? a : CTR_1;
      CTR_1:   r = taken ? CTR_0 : CTR_2;
      CTR_2:   r = taken ? b : CTR_3;
      default: r = taken ? CTR_2 : CTR_3;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tbbtb_pc_if.sv
// ----------------------------------------------------------------------------
// tbbtb_pc_if
// Valid/ready channel carrying one executed PC and its successor.
// ----------------------------------------------------------------------------
interface tbbtb_pc_if;
  import tbbtb_pkg::*;

  logic            valid;
  logic            ready;
  logic [PC_W-1:0] current_pc;
  logic [PC_W-1:0] next_pc;

  modport source (output valid, output current_pc, output next_pc, input ready);
  modport sink   (input valid, input current_pc, input next_pc, output ready);
endinterface

FILE: rtl/tbbtb_res_if.sv
// ----------------------------------------------------------------------------
// tbbtb_res_if
// Valid/ready channel carrying one lookup and update result.
// ----------------------------------------------------------------------------
interface tbbtb_res_if;
  import tbbtb_pkg::*;

  logic            valid;
  logic            ready;
  logic            skipped;
  logic            branch_taken;
  logic            hit;
  logic            hit_bank;
  logic            predicted_taken;
  logic [PC_W-1:0] predicted_target;
  logic [1:0]      verdict;
  logic            collision;
  logic [1:0]      write_action;
  logic [31:0]     hit_count;
  logic [31:0]     miss_count;
  logic [31:0]     correct_count;

  modport source (
    output valid, output skipped, output branch_taken, output hit, output hit_bank,
    output predicted_taken, output predicted_target, output verdict, output collision,
    output write_action, output hit_count, output miss_count, output correct_count,
    input ready
  );
  modport sink (
    input valid, input skipped, input branch_taken, input hit, input hit_bank,
    input predicted_taken, input predicted_target, input verdict, input collision,
    input write_action, input hit_count, input miss_count, input correct_count,
    output ready
  );
endinterface

FILE: rtl/two_bank_branch_target_buffer.sv
// ----------------------------------------------------------------------------
// two_bank_branch_target_buffer
// Two-bank branch target buffer with a 2-bit prediction state per entry.
//
// req_i carries one item: an executed PC and the PC that followed it.
// rsp_o returns one item per request: hit/miss, bank, stored prediction and
// target, verdict, collision flag, write action and the running totals.
// cfg_we_i/cfg_wdata_i write the prediction mode; write only while idle.
//
// Each bank is a synchronous memory of ENTRIES_PER_BANK words, indexed by
// PC bits [log2(ENTRIES_PER_BANK)+1:2]. An item is a read-modify-write: the
// accept edge issues the read of both banks; in the look-up state, once the
// result register is free, an edge compares, writes the entry back and loads
// the result register, which makes the result valid. req_i.ready returns
// after that, so a new item is not taken before the last one is written back.
//
// After reset a clearing pass over all ENTRIES_PER_BANK indices zeroes the valid
// bits of both banks; req_i.ready stays low meanwhile. A stalled result
// holds in the output register; the next item is still accepted, and its
// write-back waits until the register is free.
// ----------------------------------------------------------------------------
module two_bank_branch_target_buffer #(
  parameter int unsigned ENTRIES_PER_BANK = 512,
  parameter int unsigned ADDR_WIDTH       = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  tbbtb_pkg::mode_t   cfg_wdata_i,
  tbbtb_pc_if.sink           req_i,
  tbbtb_res_if.source        rsp_o
);
  import tbbtb_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES_PER_BANK);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [ADDR_WIDTH-1:0] target;
    ctr_t                  ctr;
  } entry_t;

  entry_t bank0_mem [ENTRIES_PER_BANK];
  entry_t bank1_mem [ENTRIES_PER_BANK];

  logic [1:0]            state_q, state_d;
  logic [IDX_W-1:0]      clr_cnt_q, clr_cnt_d;
  mode_t                 mode_q;
  logic [ADDR_WIDTH-1:0] cur_in, cur_q, nxt_q;
  logic [IDX_W-1:0]      rd_idx, wr_idx;
  entry_t                rd0_q, rd1_q, sel, wr_entry;
  logic                  we0, we1;
  logic                  accept, done;
  logic                  skip_c, taken_c, h0, h1, hit_c, says_c, same_c;
  logic                  correct_c, replace_c, miss_fill_c, coll_c;
  res_t                  res_c, res_q;
  logic                  rsp_valid_q, rsp_valid_d;
  logic [31:0]           hits_q, misses_q, correct_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign done        = (state_q == ST_LOOK) & (~rsp_valid_q | rsp_o.ready);

  assign cur_in = ADDR_WIDTH'(req_i.current_pc);
  assign rd_idx = cur_in[IDX_W+1:2];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q <= bank0_mem[rd_idx];
      rd1_q <= bank1_mem[rd_idx];
      cur_q <= cur_in;
      nxt_q <= ADDR_WIDTH'(req_i.next_pc);
    end
    if (we0) begin
      bank0_mem[wr_idx] <= wr_entry;
    end
    if (we1) begin
      bank1_mem[wr_idx] <= wr_entry;
    end
  end

  always_comb begin
    skip_c      = (cur_q == nxt_q);
    taken_c     = ~skip_c & (nxt_q != (cur_q + ADDR_WIDTH'(PC_STEP)));
    h0          = ~skip_c & rd0_q.valid & (rd0_q.tag == cur_q);
    h1          = ~skip_c & rd1_q.valid & (rd1_q.tag == cur_q);
    hit_c       = h0 | h1;
    sel         = h0 ? rd0_q : rd1_q;
    says_c      = ~sel.ctr[1];
    same_c      = (sel.target == nxt_q);
    correct_c   = says_c ? (taken_c & same_c) : (~taken_c | ~same_c);
    replace_c   = taken_c & ~same_c;
    miss_fill_c = ~hit_c & taken_c;
    coll_c      = taken_c & rd0_q.valid & (rd0_q.tag != cur_q)
                  & rd1_q.valid & (rd1_q.tag != cur_q);

    res_c                  = '0;
    res_c.skipped          = skip_c;
    res_c.branch_taken     = taken_c;
    res_c.hit              = hit_c;
    res_c.collision        = coll_c;
    if (hit_c) begin
      res_c.hit_bank         = ~h0;
      res_c.predicted_taken  = says_c;
      res_c.predicted_target = PC_W'(sel.target);
      res_c.verdict          = correct_c ? VERDICT_CORRECT : VERDICT_WRONG;
      if (replace_c) begin
        res_c.write_action = h0 ? WR_BANK0 : WR_BANK1;
      end
    end else if (miss_fill_c) begin
      res_c.write_action = rd0_q.valid ? WR_BANK1 : WR_BANK0;
    end

    wr_entry.valid  = 1'b1;
    wr_entry.tag    = cur_q;
    wr_entry.target = nxt_q;
    wr_entry.ctr    = fresh_ctr(mode_q);
    wr_idx          = cur_q[IDX_W+1:2];
    we0             = 1'b0;
    we1             = 1'b0;
    if (state_q == ST_CLEAR) begin
      wr_entry = '0;
      wr_idx   = clr_cnt_q;
      we0      = 1'b1;
      we1      = 1'b1;
    end else if (done) begin
      if (hit_c) begin
        we0 = h0;
        we1 = ~h0;
        if (!replace_c) begin
          wr_entry     = sel;
          wr_entry.ctr = next_ctr(sel.ctr, taken_c, mode_q);
        end
      end else if (miss_fill_c) begin
        we0 = ~rd0_q.valid;
        we1 = rd0_q.valid;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IDX_W'(ENTRIES_PER_BANK - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_d = done | (rsp_valid_q & ~rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      mode_q      <= MODE_SAT;
      rsp_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      correct_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (done) begin
        hits_q    <= hits_q + 32'(hit_c);
        misses_q  <= misses_q + 32'(miss_fill_c);
        correct_q <= correct_q + 32'(hit_c & correct_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res_c;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.skipped          = res_q.skipped;
  assign rsp_o.branch_taken     = res_q.branch_taken;
  assign rsp_o.hit              = res_q.hit;
  assign rsp_o.hit_bank         = res_q.hit_bank;
  assign rsp_o.predicted_taken  = res_q.predicted_taken;
  assign rsp_o.predicted_target = res_q.predicted_target;
  assign rsp_o.verdict          = res_q.verdict;
  assign rsp_o.collision        = res_q.collision;
  assign rsp_o.write_action     = res_q.write_action;
  assign rsp_o.hit_count        = hits_q;
  assign rsp_o.miss_count       = misses_q;
  assign rsp_o.correct_count    = correct_q;

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && hit_c |=> hits_q == $past(hits_q) + 32'd1)
    else $error("hit total did not advance on a hit");

  a_write_needs_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.write_action != WR_NONE |-> rsp_o.branch_taken)
    else $error("entry written without a taken branch");

  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.skipped |-> !rsp_o.hit && rsp_o.write_action == WR_NONE)
    else $error("skipped item touched the buffer");

  a_verdict_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.verdict != VERDICT_NONE) == rsp_o.hit)
    else $error("verdict does not match hit");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted item not looked up");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-bank branch target buffer. A directed run
// walks one entry through every prediction outcome, bank fill, collision and
// address wrap, then random phases replay small pools of hot PCs that share
// index slots, mixed with raw pairs. The phases cycle through all prediction
// modes under different sender and receiver idling. Every result is compared
// against an in-bench model of both banks and the running totals.
// ----------------------------------------------------------------------------
module tb;
  import tbbtb_pkg::*;

  localparam int unsigned IDX_N      = 512;
  localparam int unsigned HOT_N      = 24;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam mode_t       MODE_SAT_ALIAS = 2'd3;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] nxt;
  } pc_pair_t;

  typedef struct packed {
    logic        skipped;
    logic        branch_taken;
    logic        hit;
    logic        hit_bank;
    logic        predicted_taken;
    logic [31:0] predicted_target;
    verdict_t    verdict;
    logic        collision;
    wr_action_t  write_action;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] correct_count;
  } btb_result_t;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  mode_t cfg_wdata_i;

  tbbtb_pc_if  req_if ();
  tbbtb_res_if rsp_if ();

  two_bank_branch_target_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // in-bench copy of the buffer
  logic        bank_valid  [2][IDX_N];
  logic [31:0] bank_tag    [2][IDX_N];
  logic [31:0] bank_target [2][IDX_N];
  ctr_t        bank_state  [2][IDX_N];
  logic [31:0] hits_total, misses_total, correct_total;
  mode_t       mode_q;

  pc_pair_t    pending_pairs[$];
  btb_result_t expected_results[$];

  logic [31:0] hot_pc  [HOT_N];
  logic [31:0] hot_tgt [HOT_N][2];

  int unsigned gap_pct, stall_pct;
  int unsigned hold_token, hold_taken, hold_left;
  int unsigned mismatches, results_seen, hits_seen, collisions_seen, writes_seen;
  int unsigned skips_seen, idle_cycles;

  function automatic ctr_t new_entry_ctr(input mode_t m);
    return (m == MODE_BIMODAL) ? CTR_1 : CTR_0;
  endfunction

  function automatic ctr_t ctr_after(input ctr_t s, input logic taken, input mode_t m);
    ctr_t r;
    if (!taken) begin
      r = (s == CTR_3) ? CTR_3 : ctr_t'(s + 2'd1);
    end else begin
      case (s)
        CTR_0: r = (m == MODE_ALT) ? CTR_1 : CTR_0;
        CTR_1: r = CTR_0;
        CTR_2: r = (m == MODE_BIMODAL || m == MODE_ALT) ? CTR_0 : CTR_1;
        default: r = CTR_2;
      endcase
    end
    return r;
  endfunction

  function automatic btb_result_t predict_pair(input logic [31:0] pc, input logic [31:0] nxt);
    btb_result_t r;
    int unsigned slot;
    int unsigned bank;
    logic taken, h0, h1, says_taken, same, correct;
    r = '0;
    if (pc == nxt) begin
      r.skipped = 1'b1;
    end else begin
      slot = pc[10:2];
      taken = (nxt != pc + 32'd4);
      h0 = bank_valid[0][slot] && bank_tag[0][slot] == pc;
      h1 = bank_valid[1][slot] && bank_tag[1][slot] == pc;
      r.branch_taken = taken;
      r.collision = taken && bank_valid[0][slot] && !h0 && bank_valid[1][slot] && !h1;
      if (h0 || h1) begin
        bank = h0 ? 0 : 1;
        says_taken = bank_state[bank][slot] < CTR_2;
        same = bank_target[bank][slot] == nxt;
        r.hit = 1'b1;
        r.hit_bank = h1 && !h0;
        r.predicted_taken = says_taken;
        r.predicted_target = bank_target[bank][slot];
        hits_total++;
        correct = says_taken ? (taken && same) : (!taken || !same);
        r.verdict = correct ? VERDICT_CORRECT : VERDICT_WRONG;
        if (correct) correct_total++;
        if (taken && !same) begin
          bank_target[bank][slot] = nxt;
          bank_state[bank][slot] = new_entry_ctr(mode_q);
          r.write_action = (bank == 0) ? WR_BANK0 : WR_BANK1;
        end else begin
          bank_state[bank][slot] = ctr_after(bank_state[bank][slot], taken, mode_q);
        end
      end else if (taken) begin
        misses_total++;
        bank = bank_valid[0][slot] ? 1 : 0;
        bank_valid[bank][slot] = 1'b1;
        bank_tag[bank][slot] = pc;
        bank_target[bank][slot] = nxt;
        bank_state[bank][slot] = new_entry_ctr(mode_q);
        r.write_action = (bank == 0) ? WR_BANK0 : WR_BANK1;
      end
    end
    r.hit_count = hits_total;
    r.miss_count = misses_total;
    r.correct_count = correct_total;
    return r;
  endfunction

  function automatic string show(input btb_result_t r);
    return $sformatf({"skip=%0b taken=%0b hit=%0b bank=%0b ptaken=%0b ptgt=%h verdict=%0d ",
                      "coll=%0b wr=%0d hits=%0d misses=%0d correct=%0d"},
                     r.skipped, r.branch_taken, r.hit, r.hit_bank, r.predicted_taken,
                     r.predicted_target, r.verdict, r.collision, r.write_action,
                     r.hit_count, r.miss_count, r.correct_count);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_if.ready)) begin
      if (pending_pairs.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req_if.valid      <= 1'b1;
        req_if.current_pc <= pending_pairs[0].pc;
        req_if.next_pc    <= pending_pairs[0].nxt;
        void'(pending_pairs.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_token != hold_taken) begin
      hold_taken <= hold_token;
      hold_left <= HOLD_LEN;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk_i) begin
    btb_result_t got;
    btb_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < IDX_N; i++) begin
        bank_valid[0][i] = 1'b0;
        bank_valid[1][i] = 1'b0;
      end
      hits_total = '0;
      misses_total = '0;
      correct_total = '0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_results.push_back(predict_pair(req_if.current_pc, req_if.next_pc));
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.skipped, rsp_if.branch_taken, rsp_if.hit, rsp_if.hit_bank,
                rsp_if.predicted_taken, rsp_if.predicted_target, rsp_if.verdict,
                rsp_if.collision, rsp_if.write_action, rsp_if.hit_count,
                rsp_if.miss_count, rsp_if.correct_count};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", results_seen);
              $display("  expected: %s", show(want));
              $display("  actual:   %s", show(got));
            end
          end
          hits_seen += want.hit;
          collisions_seen += want.collision;
          skips_seen += want.skipped;
          writes_seen += (want.write_action != WR_NONE);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_pair(input logic [31:0] pc, input logic [31:0] nxt);
    pending_pairs.push_back('{pc, nxt});
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    mode_q <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void build_pool();
    int unsigned slot;
    logic [31:0] pc;
    for (int g = 0; g < HOT_N / 4; g++) begin
      slot = $urandom_range(IDX_N - 1);
      for (int k = 0; k < 4; k++) begin
        pc = $urandom();
        pc[10:2] = slot[8:0];
        if ($urandom_range(7) != 0) pc[1:0] = 2'b00;
        hot_pc[g * 4 + k] = pc;
        hot_tgt[g * 4 + k][0] = $urandom();
        hot_tgt[g * 4 + k][1] = $urandom();
      end
    end
  endfunction

  function automatic pc_pair_t random_pair();
    int unsigned r;
    int unsigned p;
    logic [31:0] pc;
    r = $urandom_range(99);
    p = $urandom_range(HOT_N - 1);
    pc = hot_pc[p];
    if (r < 8) return '{$urandom(), $urandom()};
    if (r < 12) begin
      pc = $urandom();
      return '{pc, pc + 32'd4};
    end
    if (r < 15) return '{pc, pc};
    if (r < 18) return '{pc, $urandom()};
    if (r < 62) return '{pc, hot_tgt[p][0]};
    if (r < 75) return '{pc, hot_tgt[p][1]};
    return '{pc, pc + 32'd4};
  endfunction

  task automatic run_phase(input mode_t m, input int unsigned gap, input int unsigned stall,
                           input int unsigned count, input logic squeeze);
    write_mode(m);
    gap_pct = gap;
    stall_pct = stall;
    build_pool();
    for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
    if (squeeze) begin
      repeat (20) @(negedge clk_i);
      hold_token++;
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = MODE_SAT;
    mode_q = MODE_SAT;
    req_if.valid = 1'b0;
    req_if.current_pc = '0;
    req_if.next_pc = '0;
    rsp_if.ready = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    hold_token = 0;
    hold_taken = 0;
    hold_left = 0;
    idle_cycles = 0;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    collisions_seen = 0;
    writes_seen = 0;
    skips_seen = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_pair(32'h0000_0000, 32'h0000_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'hFFFF_FFFC, 32'h0000_0000);
    push_pair(32'h0000_0100, 32'h0000_0104);
    push_pair(32'h0000_0100, 32'h0000_2000);
    push_pair(32'h0000_0100, 32'h0000_2000);
    push_pair(32'h0000_0100, 32'h0000_0104);
    push_pair(32'h0000_0100, 32'h0000_0104);
    push_pair(32'h0000_0100, 32'h0000_0104);
    push_pair(32'h0000_0100, 32'h0000_0104);
    push_pair(32'h0000_0100, 32'h0000_2000);
    push_pair(32'h0000_0100, 32'h0000_3000);
    push_pair(32'h0000_0100, 32'h0000_4000);
    push_pair(32'h0000_0900, 32'h0000_5000);
    push_pair(32'h0000_0900, 32'h0000_5000);
    push_pair(32'h0000_1100, 32'h0000_6000);
    push_pair(32'h0000_1100, 32'h0000_1104);
    push_pair(32'h0000_0900, 32'h0000_0904);
    push_pair(32'hFFFF_FFFF, 32'h0000_0000);
    push_pair(32'hFFFF_FFFF, 32'h0000_0003);
    push_pair(32'h0000_0000, 32'hFFFF_FFFF);
    push_pair(32'h0000_0000, 32'hFFFF_FFFF);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA);
    drain();

    run_phase(MODE_BIMODAL,   0,  0,  150, 1'b0);
    run_phase(MODE_ALT,       88, 0,  150, 1'b0);
    run_phase(MODE_SAT,       0,  88, 150, 1'b0);
    run_phase(MODE_SAT_ALIAS, 10, 10, 150, 1'b0);
    run_phase(MODE_ALT,       0,  0,  150, 1'b1);
    run_phase(MODE_BIMODAL,   88, 0,  130, 1'b0);
    run_phase(MODE_SAT,       0,  88, 130, 1'b0);
    run_phase(MODE_ALT,       10, 10, 130, 1'b0);

    mismatches += expected_results.size();
    $display("checked %0d results: %0d hits, %0d entry writes, %0d collisions, %0d skipped",
             results_seen, hits_seen, writes_seen, collisions_seen, skips_seen);
    $display("modes saturating, bimodal, alternate and the alias value; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
